[design/c2e_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c2e_pkg
// shared types, widths and the arctangent table for the cube-to-panorama remap
// ----------------------------------------------------------------------------
package c2e_pkg;

  // direction datapath width (unit 2^24, headroom for cordic growth)
  localparam int DW = 30;
  // angle width (2^32 per turn plus sign and headroom)
  localparam int AW = 36;
  localparam int UNIT_SHIFT = 24;
  localparam int LW = 4;
  localparam int MAX_TABLE = 28;

  localparam logic signed [25:0] GAIN_Q24 = 26'sd27628053;

  localparam logic [2:0] FACE_PX = 3'd0;
  localparam logic [2:0] FACE_NX = 3'd1;
  localparam logic [2:0] FACE_PY = 3'd2;
  localparam logic [2:0] FACE_NY = 3'd3;
  localparam logic [2:0] FACE_PZ = 3'd4;
  localparam logic [2:0] FACE_NZ = 3'd5;

  typedef logic signed [DW-1:0] dir_t;
  typedef logic signed [AW-1:0] ang_t;

  // values riding along with a cordic stage
  typedef struct packed {
    logic          bad_face;
    logic [LW-1:0] l;
    dir_t          yk;
    ang_t          theta;
  } side_t;

  // atan(2^-i) in turns, 2^32 per turn
  function automatic logic [31:0] atan_turns(input int idx);
    logic [31:0] r;
    r = 32'd0;
    unique case (idx)
      0:  r = 32'h20000000;  1:  r = 32'h12E4051E;  2:  r = 32'h09FB385B;
      3:  r = 32'h051111D4;  4:  r = 32'h028B0D43;  5:  r = 32'h0145D7E1;
      6:  r = 32'h00A2F61E;  7:  r = 32'h00517C55;  8:  r = 32'h0028BE53;
      9:  r = 32'h00145F2F;  10: r = 32'h000A2F98;  11: r = 32'h000517CC;
      12: r = 32'h00028BE6;  13: r = 32'h000145F3;  14: r = 32'h0000A2FA;
      15: r = 32'h0000517D;  16: r = 32'h000028BE;  17: r = 32'h0000145F;
      18: r = 32'h00000A30;  19: r = 32'h00000518;  20: r = 32'h0000028C;
      21: r = 32'h00000146;  22: r = 32'h000000A3;  23: r = 32'h00000051;
      24: r = 32'h00000029;  25: r = 32'h00000014;  26: r = 32'h0000000A;
      27: r = 32'h00000005;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

[design/c2e_cordic_stage.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c2e_cordic_stage
// one registered cordic vectoring iteration with sideband
// ----------------------------------------------------------------------------
module c2e_cordic_stage #(
  parameter int STEP = 0
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          valid_in,
  input  c2e_pkg::dir_t x_in,
  input  c2e_pkg::dir_t y_in,
  input  c2e_pkg::ang_t ang_in,
  input  c2e_pkg::side_t side_in,
  output logic          valid_out,
  output c2e_pkg::dir_t x_out,
  output c2e_pkg::dir_t y_out,
  output c2e_pkg::ang_t ang_out,
  output c2e_pkg::side_t side_out
);
  import c2e_pkg::*;

  localparam ang_t ATAN = ang_t'(atan_turns(STEP));

  logic  valid_r;
  dir_t  x_r, y_r, x_nxt, y_nxt;
  ang_t  ang_r, ang_nxt;
  side_t side_r;

  always_comb begin
    if (!y_in[DW-1]) begin
      x_nxt   = x_in + (y_in >>> STEP);
      y_nxt   = y_in - (x_in >>> STEP);
      ang_nxt = ang_in + ATAN;
    end else begin
      x_nxt   = x_in - (y_in >>> STEP);
      y_nxt   = y_in + (x_in >>> STEP);
      ang_nxt = ang_in - ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      ang_r  <= ang_nxt;
      side_r <= side_in;
    end
  end

  assign valid_out = valid_r;
  assign x_out     = x_r;
  assign y_out     = y_r;
  assign ang_out   = ang_r;
  assign side_out  = side_r;

endmodule

[design/cubemap_to_equirect_address.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cubemap_to_equirect_address
// maps a cube-map texel to the equirectangular panorama texel it samples
// ----------------------------------------------------------------------------
// pipeline: stage 0, stage 1, cordic pass one, cordic pass two, stage f1, stage f2
// throughput: one request per cycle while not stalled, set by the fully pipelined cordic chain
// the whole pipeline advances together; it stalls only when the result is held
// reset: valid bits cleared, face_size_log2 returns to 8
// ----------------------------------------------------------------------------
module cubemap_to_equirect_address #(
  parameter int MAX_FACE_LOG2 = 12,
  parameter int CORDIC_STEPS  = 20
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration: face_size_log2
  input  logic        cfg_wr_en,
  input  logic [3:0]  cfg_wr_data,
  // input requests
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // face[2:0], texel_x[14:3], texel_y[26:15]
  // results
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata   // pano_x[12:0], pano_y[24:13], pano_index[49:25]
);
  import c2e_pkg::*;

  localparam int NS = CORDIC_STEPS;
  localparam logic [LW-1:0] MAXL = LW'(MAX_FACE_LOG2);

  // global advance: move when the output slot is free or being drained
  logic en;
  assign en        = out_tready | ~out_tvalid;
  assign in_tready = en;

  logic [LW-1:0] face_log2_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      face_log2_r <= LW'(8);
    end else if (cfg_wr_en) begin
      face_log2_r <= cfg_wr_data;
    end
  end

  // ---------------- stage 0: texel centre to face-local coordinates
  logic [2:0]    in_face;
  logic [11:0]   in_tx, in_ty;
  logic [LW-1:0] l_c;
  logic [15:0]   edge_c;
  logic [11:0]   tx_m, ty_m;
  logic signed [15:0] ac, bc;
  dir_t a_c, b_c;

  assign in_face = in_tdata[2:0];
  assign in_tx   = in_tdata[14:3];
  assign in_ty   = in_tdata[26:15];

  always_comb begin
    l_c    = (face_log2_r > MAXL) ? MAXL : face_log2_r;
    edge_c = 16'd1 << l_c;
    tx_m   = in_tx & 12'(edge_c - 16'd1);
    ty_m   = in_ty & 12'(edge_c - 16'd1);
    // 2t+1-E, then scaled to unit 2^24
    ac     = $signed({3'b000, tx_m, 1'b1}) - $signed(edge_c);
    bc     = $signed({3'b000, ty_m, 1'b1}) - $signed(edge_c);
    a_c    = dir_t'(ac) <<< (UNIT_SHIFT - int'(l_c));
    b_c    = dir_t'(bc) <<< (UNIT_SHIFT - int'(l_c));
  end

  logic          s0_valid_r;
  logic [2:0]    s0_face_r;
  logic [LW-1:0] s0_l_r;
  dir_t          s0_a_r, s0_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (en) begin
      s0_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_face_r <= in_face;
      s0_l_r    <= l_c;
      s0_a_r    <= a_c;
      s0_b_r    <= b_c;
    end
  end

  // ---------------- stage 1: direction select, half-plane fold, y times gain
  localparam dir_t ONE = dir_t'(1) <<< UNIT_SHIFT;
  localparam ang_t HALF = ang_t'(1) <<< 31;

  dir_t dx_c, dy_c, dz_c, cx_c, cy_c;
  ang_t th0_c;
  logic bad_c;
  logic signed [DW+25:0] yk_prod;

  always_comb begin
    bad_c = 1'b0;
    dx_c  = ONE;
    dy_c  = -s0_b_r;
    dz_c  = -s0_a_r;
    unique case (s0_face_r)
      FACE_PX: begin dx_c = ONE;     dy_c = -s0_b_r; dz_c = -s0_a_r; end
      FACE_NX: begin dx_c = -ONE;    dy_c = -s0_b_r; dz_c = s0_a_r;  end
      FACE_PY: begin dx_c = s0_a_r;  dy_c = ONE;     dz_c = s0_b_r;  end
      FACE_NY: begin dx_c = s0_a_r;  dy_c = -ONE;    dz_c = -s0_b_r; end
      FACE_PZ: begin dx_c = s0_a_r;  dy_c = -s0_b_r; dz_c = ONE;     end
      FACE_NZ: begin dx_c = -s0_a_r; dy_c = -s0_b_r; dz_c = -ONE;    end
      default: bad_c = 1'b1;
    endcase
    // theta = atan2(x, z): fold the left half plane onto the right
    if (dz_c[DW-1]) begin
      cx_c  = -dz_c;
      cy_c  = -dx_c;
      th0_c = dx_c[DW-1] ? -HALF : HALF;
    end else begin
      cx_c  = dz_c;
      cy_c  = dx_c;
      th0_c = '0;
    end
    yk_prod = dy_c * GAIN_Q24;
  end

  // node 0 is stage 1; nodes 1..NS pass one; NS+1..2NS pass two
  logic  nv   [0:2*NS];
  dir_t  nx   [0:2*NS];
  dir_t  ny   [0:2*NS];
  ang_t  na   [0:2*NS];
  side_t nsd  [0:2*NS];

  logic  s1_valid_r;
  dir_t  s1_x_r, s1_y_r;
  ang_t  s1_a_r;
  side_t s1_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= s0_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_x_r             <= cx_c;
      s1_y_r             <= cy_c;
      s1_a_r             <= th0_c;
      s1_side_r.bad_face <= bad_c;
      s1_side_r.l        <= s0_l_r;
      s1_side_r.yk       <= dir_t'(yk_prod >>> UNIT_SHIFT);
      s1_side_r.theta    <= '0;
    end
  end

  assign nv[0]  = s1_valid_r;
  assign nx[0]  = s1_x_r;
  assign ny[0]  = s1_y_r;
  assign na[0]  = s1_a_r;
  assign nsd[0] = s1_side_r;

  // pass two starts from the final x of pass one and y*gain, angle zero
  side_t mid_side;
  always_comb begin
    mid_side       = nsd[NS];
    mid_side.theta = na[NS];
  end

  genvar g;
  generate
    for (g = 0; g < 2 * NS; g++) begin : g_cordic
      localparam int STP = (g < NS) ? g : g - NS;
      if (g == NS) begin : g_pass2_entry
        c2e_cordic_stage #(.STEP(STP)) u_stage (
          .clk(clk), .rst_n(rst_n), .en(en),
          .valid_in(nv[g]), .x_in(nx[g]), .y_in(nsd[g].yk), .ang_in('0),
          .side_in(mid_side),
          .valid_out(nv[g+1]), .x_out(nx[g+1]), .y_out(ny[g+1]),
          .ang_out(na[g+1]), .side_out(nsd[g+1])
        );
      end else begin : g_plain
        c2e_cordic_stage #(.STEP(STP)) u_stage (
          .clk(clk), .rst_n(rst_n), .en(en),
          .valid_in(nv[g]), .x_in(nx[g]), .y_in(ny[g]), .ang_in(na[g]),
          .side_in(nsd[g]),
          .valid_out(nv[g+1]), .x_out(nx[g+1]), .y_out(ny[g+1]),
          .ang_out(na[g+1]), .side_out(nsd[g+1])
        );
      end
    end
  endgenerate

  // ---------------- stage f1: angles to clamped 32-bit fractions
  localparam ang_t WORD_MAX = (ang_t'(1) <<< 32) - ang_t'(1);

  ang_t u_c, v_c;
  logic [31:0] uw_c, vw_c;
  side_t fin_side;

  assign fin_side = nsd[2*NS];

  always_comb begin
    u_c = fin_side.theta + HALF;
    v_c = HALF - (na[2*NS] <<< 1);
    if (u_c[AW-1])          uw_c = 32'd0;
    else if (u_c > WORD_MAX) uw_c = 32'hFFFF_FFFF;
    else                    uw_c = u_c[31:0];
    if (v_c[AW-1])          vw_c = 32'd0;
    else if (v_c > WORD_MAX) vw_c = 32'hFFFF_FFFF;
    else                    vw_c = v_c[31:0];
  end

  logic          f1_valid_r;
  logic [31:0]   f1_u_r, f1_v_r;
  logic [LW-1:0] f1_l_r;
  logic          f1_bad_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_valid_r <= 1'b0;
    end else if (en) begin
      f1_valid_r <= nv[2*NS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_u_r   <= uw_c;
      f1_v_r   <= vw_c;
      f1_l_r   <= fin_side.l;
      f1_bad_r <= fin_side.bad_face;
    end
  end

  // ---------------- stage f2: scale to texels, saturate, flat index
  logic [16:0] px_c, py_c, pxmax_c, pymax_c;
  logic [24:0] idx_c;
  logic [12:0] pano_x_c;
  logic [11:0] pano_y_c;
  logic [31:0] pxw, pyw;

  always_comb begin
    pxw     = f1_u_r >> (5'd31 - 5'(f1_l_r));
    pyw     = f1_v_r >> (6'd32 - 6'(f1_l_r));
    pxmax_c = (17'd2 << f1_l_r) - 17'd1;
    pymax_c = (17'd1 << f1_l_r) - 17'd1;
    px_c    = (pxw > 32'(pxmax_c)) ? pxmax_c : pxw[16:0];
    py_c    = (pyw > 32'(pymax_c)) ? pymax_c : pyw[16:0];
    idx_c   = 25'((32'(py_c) << (f1_l_r + LW'(1))) + 32'(px_c));
    pano_x_c = px_c[12:0];
    pano_y_c = py_c[11:0];
    if (f1_bad_r) begin
      pano_x_c = '0;
      pano_y_c = '0;
      idx_c    = '0;
    end
  end

  logic        out_valid_r;
  logic [49:0] out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= f1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= {idx_c, pano_y_c, pano_x_c};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_data_r};

endmodule
